@@ rtl/kmc_hop_selector_unit_defines.svh @@
// Assertion macros used by the hop selector top level.
`ifndef KMC_HOP_SELECTOR_UNIT_DEFINES_SVH
`define KMC_HOP_SELECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define KHS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hop selector check failed");

// Next-cycle implication, disabled in reset.
`define KHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hop selector check failed");

`endif

@@ rtl/khs_pkg.sv @@
// Shared types and constants of the hop selector.
package khs_pkg;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_DRAW  = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_ACK  = 2'd2;

   localparam int ID_W   = 31;
   localparam int RATE_W = 32;
   localparam int FRAC_W = 24;

   // round(ln2 * 2^32)
   localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

   // control part of the walk token
   typedef struct packed {
      logic active;
      logic found;
   } tok_type;

endpackage

@@ rtl/khs_cell.sv @@
// One neighbor slot of the selection chain.
module khs_cell #(
   parameter int SUM_W = 36
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear,
   input  logic                              wr_en,
   input  logic [khs_pkg::ID_W-1:0]          wr_id,
   input  logic [khs_pkg::RATE_W-1:0]        wr_rate,
   output logic [khs_pkg::RATE_W-1:0]        old_rate,
   input  logic [SUM_W-1:0]                  t_thresh,
   input  khs_pkg::tok_type                  tok_i,
   input  logic [SUM_W-1:0]                  run_i,
   input  logic [khs_pkg::ID_W-1:0]          id_i,
   output khs_pkg::tok_type                  tok_o,
   output logic [SUM_W-1:0]                  run_o,
   output logic [khs_pkg::ID_W-1:0]          id_o
);

   logic                       valid_ff;
   logic [khs_pkg::ID_W-1:0]   id_ff;
   logic [khs_pkg::RATE_W-1:0] rate_ff;
   khs_pkg::tok_type           tok_ff;
   logic [SUM_W-1:0]           run_ff;
   logic [khs_pkg::ID_W-1:0]   pick_ff;

   logic [SUM_W-1:0] run_in;
   logic             hit;

   assign old_rate = (wr_en && valid_ff) ? rate_ff : '0;
   assign run_in   = run_i + (valid_ff ? SUM_W'(rate_ff) : '0);
   assign hit      = tok_i.active && !tok_i.found && valid_ff && (t_thresh < run_in);

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= 1'b1;
      end
      if (wr_en) begin
         id_ff   <= wr_id;
         rate_ff <= wr_rate;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff.active <= tok_i.active;
         tok_ff.found  <= tok_i.found || hit;
      end
      run_ff  <= run_in;
      pick_ff <= hit ? id_ff : id_i;
   end

   assign tok_o = tok_ff;
   assign run_o = run_ff;
   assign id_o  = pick_ff;

endmodule

@@ rtl/khs_dwell.sv @@
// Dwell time unit: iterative log2 by squaring, ln2 scale, restoring divide.
module khs_dwell #(
   parameter int SUM_W = 36
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      u_dwell,
   input  logic [SUM_W-1:0] sum,
   output logic             done,
   output logic [31:0]      dwell
);

   typedef enum logic [2:0] {
      D_IDLE, D_NORM, D_LOG, D_MUL, D_PREP, D_DIV
   } dstate_type;

   dstate_type  state_ff;
   logic [31:0] m_ff;
   logic [4:0]  shift_ff;
   logic [4:0]  cnt_ff;
   logic [khs_pkg::FRAC_W-1:0] f_ff;
   logic [61:0] prod_ff;
   logic [SUM_W-1:0] r_ff;
   logic [31:0] lo_ff;
   logic [31:0] q_ff;
   logic        done_ff;
   logic [31:0] dwell_ff;

   logic [4:0]  amt;
   logic [63:0] sq;
   logic [32:0] sq_top;
   logic [29:0] nl2;
   logic [37:0] lh;
   logic [SUM_W:0] trial;
   logic        qbit;

   always_comb begin
      amt    = 5'd16 >> cnt_ff[2:0];
      sq     = 64'(m_ff) * 64'(m_ff);
      sq_top = sq[63:31];
      nl2    = ((30'(shift_ff) + 30'd1) << khs_pkg::FRAC_W) - 30'(f_ff);
      lh     = prod_ff[61:24];
      trial  = {r_ff, lo_ff[31]};
      qbit   = trial >= {1'b0, sum};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            D_IDLE: begin
               done_ff <= start && (u_dwell == '0);
               if (start) begin
                  if (u_dwell == '0) begin
                     dwell_ff <= '1;
                  end else begin
                     m_ff     <= u_dwell;
                     shift_ff <= '0;
                     cnt_ff   <= '0;
                     f_ff     <= '0;
                     state_ff <= D_NORM;
                  end
               end
            end
            D_NORM: begin
               done_ff <= 1'b0;
               // binary search for the leading one: 16, 8, 4, 2, 1
               if ((m_ff >> (6'd32 - 6'(amt))) == '0) begin
                  m_ff     <= m_ff << amt;
                  shift_ff <= shift_ff + amt;
               end
               if (cnt_ff == 5'd4) begin
                  cnt_ff   <= '0;
                  state_ff <= D_LOG;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            D_LOG: begin
               done_ff <= 1'b0;
               m_ff    <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
               f_ff    <= {f_ff[khs_pkg::FRAC_W-2:0], sq_top[32]};
               cnt_ff  <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(khs_pkg::FRAC_W - 1)) begin
                  state_ff <= D_MUL;
               end
            end
            D_MUL: begin
               done_ff  <= 1'b0;
               prod_ff  <= 62'(nl2) * 62'(khs_pkg::LN2_Q32);
               state_ff <= D_PREP;
            end
            D_PREP: begin
               if ((sum >> 37) != '0) begin
                  dwell_ff <= '0;
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end else if ((SUM_W + 6)'(sum) <= (SUM_W + 6)'(lh[37:32])) begin
                  dwell_ff <= '1;
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end else begin
                  done_ff  <= 1'b0;
                  r_ff     <= SUM_W'(lh[37:32]);
                  lo_ff    <= lh[31:0];
                  cnt_ff   <= '0;
                  state_ff <= D_DIV;
               end
            end
            D_DIV: begin
               r_ff    <= qbit ? SUM_W'(trial - {1'b0, sum}) : trial[SUM_W-1:0];
               lo_ff   <= lo_ff << 1;
               q_ff    <= {q_ff[30:0], qbit};
               cnt_ff  <= cnt_ff + 5'd1;
               done_ff <= (cnt_ff == 5'd31);
               if (cnt_ff == 5'd31) begin
                  dwell_ff <= {q_ff[30:0], qbit};
                  state_ff <= D_IDLE;
               end
            end
            default: begin
               done_ff  <= 1'b0;
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

   assign done  = done_ff;
   assign dwell = dwell_ff;

endmodule

@@ rtl/kmc_hop_selector_unit.sv @@
// Top level of the kinetic Monte Carlo hop selector.
//
// Usage: an item is taken when start is high and busy is low. op 0 clears
// the neighbor table, op 1 writes one slot (id and Q16.16 rate), op 2 draws.
// Every item gives exactly one result, shown for one cycle with rsp_valid.
//
// Clear and write finish in one cycle: the ack strobes in the cycle after
// the item is taken and busy stays low, so writes can go back to back.
// A draw holds busy high. The states S_TLO and S_THI form the pick threshold
// u_hop*sum, then a token walks the chain of slot cells, one cell per cycle;
// the walk path is done when the token leaves the last cell. The dwell unit
// runs in parallel: 5 normalize steps, 24 squaring steps, one multiply, one
// check and 32 divide steps; with a full divide its path is the slower one
// at the default size. A zero u_dwell skips the dwell work; a saturating
// quotient ends at the check. Busy drops in the strobe cycle, so the next
// item can be taken at the edge that ends it.
//
// Reset clears all valid bits and the rate total; slot ids stay undefined
// until written. The receiver cannot stall: results are never held.
`include "kmc_hop_selector_unit_defines.svh"

module kmc_hop_selector_unit #(
   parameter int MAX_NEIGHBORS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_slot,
   input  logic [30:0] req_neighbor_id,
   input  logic [31:0] req_rate,
   input  logic [31:0] req_u_hop,
   input  logic [31:0] req_u_dwell,
   output logic        rsp_valid,
   output logic [30:0] rsp_next_site,
   output logic [31:0] rsp_dwell_time,
   output logic [1:0]  rsp_status
);

   localparam int CLOG  = $clog2(MAX_NEIGHBORS);
   localparam int SUM_W = 32 + ((CLOG > 0) ? CLOG : 1);

   typedef enum logic [1:0] {S_IDLE, S_TLO, S_THI, S_WALK} state_type;

   state_type        state_ff;
   logic [SUM_W-1:0] rate_total_ff;
   logic [31:0]      uh_ff;
   logic [63:0]      plo_ff;
   logic [SUM_W-1:0] t_ff;
   logic             inject_ff;
   logic             walk_done_ff;
   logic             found_ff;
   logic [30:0]      pick_id_ff;
   logic             dw_done_ff;
   logic [31:0]      dw_val_ff;
   logic             rsp_valid_ff;
   logic [30:0]      rsp_next_ff;
   logic [31:0]      rsp_dwell_ff;
   logic [1:0]       rsp_status_ff;

   logic             accept;
   logic             draw_go;
   logic [MAX_NEIGHBORS-1:0] wr_en;
   logic [31:0]      old_rate [MAX_NEIGHBORS];
   logic [31:0]      old_sel;
   logic [SUM_W-1:0] rate_total_in;
   logic [SUM_W-1:0] t_in;
   logic             dw_done;
   logic [31:0]      dw_val;
   logic             rsp_ok;
   logic             rsp_ack;

   khs_pkg::tok_type tok_chain [MAX_NEIGHBORS+1];
   logic [SUM_W-1:0] run_chain [MAX_NEIGHBORS+1];
   logic [30:0]      id_chain  [MAX_NEIGHBORS+1];

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign draw_go = accept && (req_op == khs_pkg::OP_DRAW);

   // head of the chain: a fresh token for one cycle
   assign tok_chain[0].active = inject_ff;
   assign tok_chain[0].found  = 1'b0;
   assign run_chain[0]        = '0;
   assign id_chain[0]         = '0;

   for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
      assign wr_en[i] = accept && (req_op == khs_pkg::OP_WRITE) && (32'(req_slot) == i);

      khs_cell #(.SUM_W(SUM_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (accept && (req_op == khs_pkg::OP_CLEAR)),
         .wr_en    (wr_en[i]),
         .wr_id    (req_neighbor_id),
         .wr_rate  (req_rate),
         .old_rate (old_rate[i]),
         .t_thresh (t_ff),
         .tok_i    (tok_chain[i]),
         .run_i    (run_chain[i]),
         .id_i     (id_chain[i]),
         .tok_o    (tok_chain[i+1]),
         .run_o    (run_chain[i+1]),
         .id_o     (id_chain[i+1])
      );
   end

   // rate of the slot being overwritten (zero when not valid)
   always_comb begin
      old_sel = '0;
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
         old_sel = old_sel | old_rate[i];
      end
   end

   assign rate_total_in = rate_total_ff - SUM_W'(old_sel) + SUM_W'(req_rate);

   // t = u_hop*Sh + floor(u_hop*Sl / 2^32); below the sum whenever the sum is not zero
   assign t_in = SUM_W'((SUM_W + 32)'(uh_ff) * (SUM_W + 32)'(rate_total_ff[SUM_W-1:32])
                        + (SUM_W + 32)'(plo_ff[63:32]));

   khs_dwell #(.SUM_W(SUM_W)) u_dwell (
      .clock   (clock),
      .reset   (reset),
      .start   (draw_go),
      .u_dwell (req_u_dwell),
      .sum     (rate_total_ff),
      .done    (dw_done),
      .dwell   (dw_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rate_total_ff <= '0;
         inject_ff     <= 1'b0;
         walk_done_ff  <= 1'b0;
         dw_done_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // ack right after any item that is not a draw; draw result once both paths finish
         rsp_valid_ff <= (accept && (req_op != khs_pkg::OP_DRAW))
                         || ((state_ff == S_WALK) && walk_done_ff && dw_done_ff);
         inject_ff    <= (state_ff == S_THI);
         if (draw_go) begin
            walk_done_ff <= 1'b0;
            dw_done_ff   <= 1'b0;
         end else begin
            if (dw_done) begin
               dw_done_ff <= 1'b1;
            end
            if (tok_chain[MAX_NEIGHBORS].active) begin
               walk_done_ff <= 1'b1;
            end
         end
         if (dw_done) begin
            dw_val_ff <= dw_val;
         end
         if (tok_chain[MAX_NEIGHBORS].active) begin
            found_ff   <= tok_chain[MAX_NEIGHBORS].found;
            pick_id_ff <= id_chain[MAX_NEIGHBORS];
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_op)
                     khs_pkg::OP_CLEAR: rate_total_ff <= '0;
                     khs_pkg::OP_WRITE: begin
                        if (|wr_en) begin
                           rate_total_ff <= rate_total_in;
                        end
                     end
                     default: ;
                  endcase
                  if (req_op == khs_pkg::OP_DRAW) begin
                     uh_ff    <= req_u_hop;
                     state_ff <= S_TLO;
                  end else begin
                     rsp_next_ff   <= '0;
                     rsp_dwell_ff  <= '0;
                     rsp_status_ff <= khs_pkg::ST_ACK;
                  end
               end
            end
            S_TLO: begin
               plo_ff   <= 64'(uh_ff) * 64'(rate_total_ff[31:0]);
               state_ff <= S_THI;
            end
            S_THI: begin
               t_ff     <= t_in;
               state_ff <= S_WALK;
            end
            S_WALK: begin
               if (walk_done_ff && dw_done_ff) begin
                  state_ff <= S_IDLE;
                  if (found_ff) begin
                     rsp_next_ff   <= pick_id_ff;
                     rsp_dwell_ff  <= dw_val_ff;
                     rsp_status_ff <= khs_pkg::ST_OK;
                  end else begin
                     rsp_next_ff   <= '0;
                     rsp_dwell_ff  <= '1;
                     rsp_status_ff <= khs_pkg::ST_NONE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_site  = rsp_next_ff;
   assign rsp_dwell_time = rsp_dwell_ff;
   assign rsp_status     = rsp_status_ff;

   assign rsp_ok  = rsp_valid && (rsp_status == khs_pkg::ST_OK);
   assign rsp_ack = rsp_valid && (rsp_status == khs_pkg::ST_ACK);

   `KHS_ASSERT_IMP(a_ok_needs_sum, clock, reset, rsp_ok, rate_total_ff != '0)
   `KHS_ASSERT_NEXT(a_draw_sets_busy, clock, reset, draw_go, busy)
   `KHS_ASSERT_IMP(a_ack_is_zero, clock, reset, rsp_ack, (rsp_next_site | rsp_dwell_time) == '0)
   `KHS_ASSERT_IMP(a_token_in_walk, clock, reset, tok_chain[MAX_NEIGHBORS].active, busy)

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the kinetic Monte Carlo hop selector.
module tb_top;

   localparam int NSLOT = 16;
   localparam int WDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      logic [1:0]  op;
      logic [3:0]  slot;
      logic [30:0] nid;
      logic [31:0] rate;
      logic [31:0] u_hop;
      logic [31:0] u_dwell;
   } hop_item_type;

   typedef struct {
      logic [30:0] next_site;
      logic [31:0] dwell;
      logic [1:0]  status;
   } hop_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = '0;
   logic [3:0]  req_slot = '0;
   logic [30:0] req_neighbor_id = '0;
   logic [31:0] req_rate = '0;
   logic [31:0] req_u_hop = '0;
   logic [31:0] req_u_dwell = '0;
   logic        rsp_valid;
   logic [30:0] rsp_next_site;
   logic [31:0] rsp_dwell_time;
   logic [1:0]  rsp_status;

   kmc_hop_selector_unit dut (.*);

   always #5 clock = ~clock;

   // predictor state: the model table
   logic [30:0] tbl_id [NSLOT];
   logic [31:0] tbl_rate [NSLOT];
   logic        tbl_valid [NSLOT];
   logic [63:0] tbl_total;

   hop_item_type   pending_items[$];
   hop_result_type expected_results[$];
   int             send_idle_pct = 0;
   bit             hold_send = 1'b0;
   bit             stim_done = 1'b0;
   int             fail_count = 0;
   int             quiet_cycles = 0;

   // -ln(u)/sum in Q16.16: log2 by repeated squaring, times ln2, divided
   function automatic logic [31:0] dwell_calc(logic [31:0] u, logic [63:0] sum);
      int          n;
      logic [63:0] m, nl2, l, q;
      logic [31:0] f;
      if (u == 0) return 32'hFFFF_FFFF;
      n = 31;
      while (u[n] == 1'b0) n--;
      m = ({32'd0, u} << (31 - n)) & 64'hFFFF_FFFF;
      f = 0;
      for (int i = 0; i < khs_pkg::FRAC_W; i++) begin
         m = (m * m) >> 31;
         f = f << 1;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            f[0] = 1'b1;
         end
      end
      nl2 = (64'(32 - n) << khs_pkg::FRAC_W) - 64'(f);
      l = nl2 * 64'(khs_pkg::LN2_Q32);
      if ((sum >> 37) != 0) return 32'd0;
      q = l / (sum << khs_pkg::FRAC_W);
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic void table_clear();
      for (int i = 0; i < NSLOT; i++) begin
         tbl_rate[i] = '0;
         tbl_valid[i] = 1'b0;
      end
      tbl_total = '0;
   endfunction

   // append one item to the stimulus queue
   function automatic void queue_item(hop_item_type it);
      pending_items.insert(pending_items.size(), it);
   endfunction

   // advance the table model by one item and return the expected result
   function automatic hop_result_type hop_predict(hop_item_type it);
      hop_result_type r;
      logic [63:0] t, run;
      bit          found;
      r.next_site = '0;
      r.dwell = '0;
      r.status = khs_pkg::ST_ACK;
      if (it.op == khs_pkg::OP_CLEAR) begin
         table_clear();
      end else if (it.op == khs_pkg::OP_WRITE) begin
         if (tbl_valid[it.slot]) tbl_total -= 64'(tbl_rate[it.slot]);
         tbl_id[it.slot] = it.nid;
         tbl_rate[it.slot] = it.rate;
         tbl_valid[it.slot] = 1'b1;
         tbl_total += 64'(it.rate);
      end else if (it.op == khs_pkg::OP_DRAW) begin
         r.status = khs_pkg::ST_NONE;
         r.dwell = 32'hFFFF_FFFF;
         t = 64'(it.u_hop) * (tbl_total >> 32)
             + ((64'(it.u_hop) * (tbl_total & 64'hFFFF_FFFF)) >> 32);
         run = 0;
         found = 1'b0;
         if (tbl_total != 0) begin
            for (int i = 0; i < NSLOT && !found; i++) begin
               if (tbl_valid[i]) begin
                  run += 64'(tbl_rate[i]);
                  if (t < run) begin
                     found = 1'b1;
                     r.next_site = tbl_id[i];
                  end
               end
            end
            if (found) begin
               r.status = khs_pkg::ST_OK;
               r.dwell = dwell_calc(it.u_dwell, tbl_total);
            end
         end
      end
      return r;
   endfunction

   function automatic hop_item_type mk_item(logic [1:0] op, logic [3:0] slot, logic [30:0] nid,
                                            logic [31:0] rate, logic [31:0] uh,
                                            logic [31:0] ud);
      hop_item_type it;
      it.op = op; it.slot = slot; it.nid = nid;
      it.rate = rate; it.u_hop = uh; it.u_dwell = ud;
      return it;
   endfunction

   function automatic logic [31:0] rnd_rate();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 255);
         3: return $urandom_range(1, 32'h0001_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rnd_u();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'd1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // Driver: one nonblocking update of start per edge; item held until taken.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         hop_item_type it;
         if (start && !busy) begin
            expected_results.insert(expected_results.size(),
                                    hop_predict(pending_items.pop_front()));
         end
         if ((start && busy) ||
             (pending_items.size() > 0 && !hold_send &&
              $urandom_range(0, 99) >= send_idle_pct)) begin
            if (!(start && busy)) begin
               it = pending_items[0];
               req_op <= it.op;
               req_slot <= it.slot;
               req_neighbor_id <= it.nid;
               req_rate <= it.rate;
               req_u_hop <= it.u_hop;
               req_u_dwell <= it.u_dwell;
            end
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compare each strobed result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         hop_result_type e;
         if (expected_results.size() == 0) begin
            $error("result with nothing expected: site %0h dwell %0h status %0d",
                   rsp_next_site, rsp_dwell_time, rsp_status);
            fail_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_next_site !== e.next_site) begin
               $error("next_site expected %0h actual %0h", e.next_site, rsp_next_site);
               fail_count++;
            end
            if (rsp_dwell_time !== e.dwell) begin
               $error("dwell_time expected %0h actual %0h", e.dwell, rsp_dwell_time);
               fail_count++;
            end
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: cycles with neither an item nor a result accepted.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || stim_done) quiet_cycles <= 0;
      else if (pending_items.size() > 0 || expected_results.size() > 0) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WDOG_LIMIT) begin
            $display("** kmc_hop_selector_unit: FAILED **");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_items.size() > 0 || start || expected_results.size() > 0)
         @(posedge clock);
   endtask

   // ids rise from write to write, as the host writes them
   task automatic queue_table(int nslots, bit full_range);
      logic [30:0] nid;
      nid = 31'($urandom_range(0, 1000));
      queue_item(mk_item(khs_pkg::OP_CLEAR, 4'($urandom), 31'($urandom), $urandom,
                         $urandom, $urandom));
      for (int s = 0; s < nslots; s++) begin
         nid = nid + 31'($urandom_range(1, 1000));
         queue_item(mk_item(khs_pkg::OP_WRITE, 4'(full_range ? s : $urandom_range(0, 15)),
                            nid, rnd_rate(), $urandom, $urandom));
      end
   endtask

   initial begin
      int count;
      table_clear();
      for (int i = 0; i < NSLOT; i++) tbl_id[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: draw on empty table, extremes, zero-rate slots, overwrite, op 3
      queue_item(mk_item(khs_pkg::OP_DRAW, 4'd0, 31'd0, 32'd0, 32'd0, 32'd0));
      queue_item(mk_item(khs_pkg::OP_WRITE, 4'd0, 31'd5, 32'd0, 32'd0, 32'd0));
      queue_item(mk_item(khs_pkg::OP_DRAW, 4'd0, 31'd0, 32'd0, 32'hFFFF_FFFF, 32'd7));
      queue_item(mk_item(khs_pkg::OP_WRITE, 4'd3, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_item(mk_item(khs_pkg::OP_DRAW, 4'hF, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
                         32'd0, 32'd0));
      queue_item(mk_item(khs_pkg::OP_DRAW, 4'd0, 31'd0, 32'd0, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF));
      queue_item(mk_item(khs_pkg::OP_DRAW, 4'd0, 31'd0, 32'd0, 32'h8000_0000, 32'd1));
      queue_item(mk_item(2'd3, 4'hF, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_item(mk_item(khs_pkg::OP_WRITE, 4'd3, 31'd9, 32'd1, 32'd0, 32'd0));
      queue_item(mk_item(khs_pkg::OP_DRAW, 4'd0, 31'd0, 32'd0, 32'hFFFF_FFFF,
                         32'h8000_0000));
      for (int s = 0; s < NSLOT; s++)
         queue_item(mk_item(khs_pkg::OP_WRITE, 4'(s), 31'(100 + s), 32'hFFFF_FFFF,
                            32'd0, 32'd0));
      queue_item(mk_item(khs_pkg::OP_DRAW, 4'd0, 31'd0, 32'd0, 32'hFFFF_FFFF, 32'd3));
      queue_item(mk_item(khs_pkg::OP_CLEAR, 4'd0, 31'd0, 32'd0, 32'd0, 32'd0));
      queue_item(mk_item(khs_pkg::OP_DRAW, 4'd0, 31'd0, 32'd0, 32'd1, 32'd1));
      wait_drained();

      // random: mostly built tables then draws, under several idle mixes
      count = 0;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 68 : (ph == 3) ? 18 : 0;
         while (count < (ph + 1) * 350) begin
            if ($urandom_range(0, 9) == 0) begin
               queue_item(mk_item(2'($urandom), 4'($urandom), 31'($urandom),
                                  $urandom, $urandom, $urandom));
               count++;
            end else begin
               int n;
               n = $urandom_range(0, 3) == 0 ? NSLOT : $urandom_range(1, 6);
               queue_table(n, $urandom_range(0, 1));
               count += n + 1;
               repeat ($urandom_range(1, 8)) begin
                  queue_item(mk_item(khs_pkg::OP_DRAW, 4'($urandom), 31'($urandom),
                                     $urandom, rnd_u(), rnd_u()));
                  count++;
               end
            end
         end
         if (ph == 1) begin
            // wait until everything has come back, then hold the sender off
            wait_drained();
            hold_send = 1'b1;
            repeat (5) @(posedge clock);
            hold_send = 1'b0;
         end
      end
      wait_drained();
      stim_done = 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("** kmc_hop_selector_unit: PASSED **");
      else $display("** kmc_hop_selector_unit: FAILED **");
      $finish;
   end
endmodule
